/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the Fibonacci search table design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define FST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define FST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/fst_pkg.sv */
// ---------------------------------------------------------------------------
// Fibonacci search table package
// Widths, codes, Fibonacci constants and shared types of the search table.
// ---------------------------------------------------------------------------
package fst_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = IDX_W + 1;
  localparam int DATA_W      = 32;

  // Fibonacci levels: F(17) = 1597 is the first value at or above the depth.
  localparam int LVL_MAX     = 17;
  localparam int LVL_W       = 5;
  localparam int FIB_W       = 11;

  // Configuration port.
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // Item commands.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Register indexes.
  localparam logic [CFG_ADDR_W-3:0] REG_ARRAY_LENGTH = '0;

  // Request from the controller to the table memory.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] wr_data;
  } tbl_req_t;

  // One search result.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } res_t;

  // Fibonacci number F(k), with F(0) = 0 and F(1) = 1.
  function automatic logic [FIB_W-1:0] fib(input logic [LVL_W-1:0] k);
    logic [FIB_W-1:0] f;
    case (k)
      5'd0:    f = 11'd0;
      5'd1:    f = 11'd1;
      5'd2:    f = 11'd1;
      5'd3:    f = 11'd2;
      5'd4:    f = 11'd3;
      5'd5:    f = 11'd5;
      5'd6:    f = 11'd8;
      5'd7:    f = 11'd13;
      5'd8:    f = 11'd21;
      5'd9:    f = 11'd34;
      5'd10:   f = 11'd55;
      5'd11:   f = 11'd89;
      5'd12:   f = 11'd144;
      5'd13:   f = 11'd233;
      5'd14:   f = 11'd377;
      5'd15:   f = 11'd610;
      5'd16:   f = 11'd987;
      5'd17:   f = 11'd1597;
      default: f = 11'd1597;
    endcase
    return f;
  endfunction

  // Smallest level k >= 2 with F(k) >= n.
  function automatic logic [LVL_W-1:0] fib_level(input logic [LEN_W-1:0] n);
    logic [LVL_W-1:0] lvl;
    lvl = LVL_W'(LVL_MAX);
    for (int k = LVL_MAX; k >= 2; k--) begin
      if (fib(LVL_W'(k)) >= FIB_W'(n)) begin
        lvl = LVL_W'(k);
      end
    end
    return lvl;
  endfunction

endpackage

/* design/fst_if.sv */
// ---------------------------------------------------------------------------
// Fibonacci search table channels
// Valid/ready channels for command words and result words.
// ---------------------------------------------------------------------------

// Command channel: write an entry or search for a key.
interface fst_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [fst_pkg::IDX_W-1:0]   entry_index;
  logic signed [fst_pkg::DATA_W-1:0] data_value;

  modport source (output valid, cmd, entry_index, data_value, input ready);
  modport sink   (input valid, cmd, entry_index, data_value, output ready);
endinterface

// Result channel: one word per search.
interface fst_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [fst_pkg::IDX_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

/* design/fst_table.sv */
// ---------------------------------------------------------------------------
// Fibonacci search table memory
// Single-port synchronous store of the table entries with a registered read.
// ---------------------------------------------------------------------------
module fst_table (
  input  logic                         clk,
  input  fst_pkg::tbl_req_t            req,
  output logic [fst_pkg::DATA_W-1:0]   rd_data
);

  logic [fst_pkg::DATA_W-1:0] mem [fst_pkg::TABLE_DEPTH];
  logic [fst_pkg::DATA_W-1:0] rd_data_r;

  // Write and registered read share the one address port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/fst_ctrl.sv */
// ---------------------------------------------------------------------------
// Fibonacci search controller
// Takes command words, writes entries and walks the Fibonacci search
// through the table memory, each probe a read state followed by a compare state.
// ---------------------------------------------------------------------------
module fst_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  fst_in_if.sink                      in_ch,
  input  logic [fst_pkg::LEN_W-1:0]   cfg_len,
  output fst_pkg::tbl_req_t           tbl_req,
  input  logic [fst_pkg::DATA_W-1:0]  tbl_rd_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output fst_pkg::res_t               res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_TAIL,
    ST_TAIL_CMP,
    ST_DONE
  } state_t;

  state_t                       state_r;
  logic [fst_pkg::DATA_W-1:0]   key_r;
  logic [fst_pkg::LEN_W-1:0]    n_r;
  logic [fst_pkg::LVL_W-1:0]    lvl_r;
  logic [fst_pkg::LEN_W-1:0]    o1_r;     // offset plus one
  logic [fst_pkg::IDX_W-1:0]    idx_r;
  logic                         found_r;
  logic [fst_pkg::IDX_W-1:0]    pos_r;

  logic                         accept;
  logic [fst_pkg::LEN_W-1:0]    n_sat;
  logic [fst_pkg::LVL_W-1:0]    start_lvl;
  logic [fst_pkg::LEN_W:0]      probe_sum;
  logic [fst_pkg::LEN_W:0]      probe_max;
  logic [fst_pkg::IDX_W-1:0]    probe_idx;
  logic                         tail_ok;
  logic                         cmp_lt;
  logic                         cmp_eq;
  logic [fst_pkg::LVL_W-1:0]    lvl_nxt;

  assign accept = in_ch.valid && (state_r == ST_IDLE);
  assign in_ch.ready = (state_r == ST_IDLE);

  // Length saturates at the table depth.
  assign n_sat = (cfg_len > fst_pkg::LEN_W'(fst_pkg::TABLE_DEPTH)) ?
                 fst_pkg::LEN_W'(fst_pkg::TABLE_DEPTH) : cfg_len;
  assign start_lvl = fst_pkg::fib_level(n_sat);

  // Probe index is offset + F(k-2), clamped to the last active entry.
  always_comb begin
    probe_sum = {1'b0, o1_r} + {1'b0, fst_pkg::fib(lvl_r - fst_pkg::LVL_W'(2))}
                - (fst_pkg::LEN_W+1)'(1);
    probe_max = {1'b0, n_r} - (fst_pkg::LEN_W+1)'(1);
    if (probe_sum > probe_max) begin
      probe_idx = probe_max[fst_pkg::IDX_W-1:0];
    end else begin
      probe_idx = probe_sum[fst_pkg::IDX_W-1:0];
    end
  end

  // The last compare needs F(k-1) nonzero and offset + 1 inside the length.
  assign tail_ok = (lvl_r >= fst_pkg::LVL_W'(2)) && (o1_r < n_r);

  // Signed compare of the fetched entry against the key.
  assign cmp_lt = $signed(tbl_rd_data) < $signed(key_r);
  assign cmp_eq = tbl_rd_data == key_r;
  assign lvl_nxt = cmp_lt ? (lvl_r - fst_pkg::LVL_W'(1)) : (lvl_r - fst_pkg::LVL_W'(2));

  // Memory requests.
  always_comb begin
    tbl_req = '0;
    case (state_r)
      ST_IDLE: begin
        tbl_req.wr_en   = accept && (in_ch.cmd == fst_pkg::CMD_WRITE);
        tbl_req.addr    = in_ch.entry_index;
        tbl_req.wr_data = in_ch.data_value;
      end
      ST_PROBE: begin
        tbl_req.rd_en = 1'b1;
        tbl_req.addr  = probe_idx;
      end
      ST_TAIL: begin
        tbl_req.rd_en = tail_ok;
        tbl_req.addr  = o1_r[fst_pkg::IDX_W-1:0];
      end
      default: begin
        tbl_req = '0;
      end
    endcase
  end

  // Search sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      found_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept && (in_ch.cmd == fst_pkg::CMD_SEARCH)) begin
            key_r   <= in_ch.data_value;
            n_r     <= n_sat;
            lvl_r   <= start_lvl;
            o1_r    <= '0;
            found_r <= 1'b0;
            pos_r   <= '0;
            if (n_sat == '0) begin
              state_r <= ST_DONE;
            end else if (start_lvl >= fst_pkg::LVL_W'(3)) begin
              state_r <= ST_PROBE;
            end else begin
              state_r <= ST_TAIL;
            end
          end
        end
        ST_PROBE: begin
          idx_r   <= probe_idx;
          state_r <= ST_COMPARE;
        end
        ST_COMPARE: begin
          if (cmp_eq) begin
            found_r <= 1'b1;
            pos_r   <= idx_r;
            state_r <= ST_DONE;
          end else begin
            if (cmp_lt) begin
              o1_r <= {1'b0, idx_r} + fst_pkg::LEN_W'(1);
            end
            lvl_r   <= lvl_nxt;
            state_r <= (lvl_nxt >= fst_pkg::LVL_W'(3)) ? ST_PROBE : ST_TAIL;
          end
        end
        ST_TAIL: begin
          state_r <= tail_ok ? ST_TAIL_CMP : ST_DONE;
        end
        ST_TAIL_CMP: begin
          if (cmp_eq) begin
            found_r <= 1'b1;
            pos_r   <= o1_r[fst_pkg::IDX_W-1:0];
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid    = (state_r == ST_DONE);
  assign res.found    = found_r;
  assign res.position = pos_r;

endmodule

/* design/fibonacci_search_table_unit.sv */
// A write word is taken while the controller is idle; a search word runs P probes (at most
// 15 for 1024 entries) and at most one tail compare, and its result word then passes
// through the output register; the next word is taken once the controller is idle again.
// Each probe is a memory read state followed by a compare state; one word at a time.
// Reset clears array_length, controller state and the output valid flag; table entries are not cleared.
// ---------------------------------------------------------------------------
// Fibonacci search table unit
// Top level: configuration port, search controller, table memory and the
// result output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fibonacci_search_table_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  fst_in_if.sink                              in_ch,
  fst_out_if.source                           out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fst_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [fst_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [fst_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  logic [fst_pkg::LEN_W-1:0]  len_r;
  logic                       reg_hit;
  fst_pkg::tbl_req_t          tbl_req;
  logic [fst_pkg::DATA_W-1:0] tbl_rd_data;
  logic                       res_valid;
  logic                       res_ready;
  fst_pkg::res_t              res;
  logic                       out_valid_r;
  fst_pkg::res_t              out_word_r;

  // Configuration register.
  assign reg_hit    = cfg_paddr[fst_pkg::CFG_ADDR_W-1:2] == fst_pkg::REG_ARRAY_LENGTH;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_hit ? fst_pkg::CFG_DATA_W'(len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && reg_hit) begin
      len_r <= cfg_pwdata[fst_pkg::LEN_W-1:0];
    end
  end

  // Search controller and table memory.
  fst_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_len     (len_r),
    .tbl_req     (tbl_req),
    .tbl_rd_data (tbl_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  fst_table u_table (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_rd_data)
  );

  // Output register: a result word waits here while the controller goes idle.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        out_word_r <= res;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_word_r.found;
  assign out_ch.position = out_word_r.position;

  // A miss always reports position zero.
  `FST_ASSERT(a_miss_pos_zero, out_ch.valid && !out_ch.found |-> out_ch.position == '0, "miss pos")
  // The table port never reads and writes in the same cycle.
  `FST_ASSERT_ALWAYS(a_port_excl, !(tbl_req.wr_en && tbl_req.rd_en), "table read and write collide")
  // No new word is taken while a search result is pending in the controller.
  `FST_ASSERT(a_busy_block, res_valid |-> !in_ch.ready, "word accepted during pending result")

endmodule
